FILE: rtl/scid_pkg.sv
// ----------------------------------------------------------------------------
// scid_pkg: shared types and constants of the size-class ID allocator
// Request and response payloads, opcodes, status codes, controller states,
// and the per-class sizing tables used by the datapath and the FIFO memory.
// ----------------------------------------------------------------------------
package scid_pkg;

  // Port field widths.
  localparam int ID_W    = 16;
  localparam int COUNT_W = 12;

  // Defaults of the top-level parameters.
  localparam int ID_BITS_DEF        = 16;
  localparam int MAX_MESH_COUNT_DEF = 2048;

  localparam int NUM_CLASSES = 4;
  localparam int CLASS_W     = 2;

  // Sub-index bits and free FIFO depth of each class.
  localparam int SUB_BITS   [NUM_CLASSES] = '{2, 5, 8, 11};
  localparam int FIFO_DEPTH [NUM_CLASSES] = '{4096, 512, 64, 8};
  localparam int FIFO_AW    [NUM_CLASSES] = '{12, 9, 6, 3};

  // Widest FIFO address and a fill count that can hold the deepest FIFO.
  localparam int PTR_W  = 12;
  localparam int FILL_W = 13;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_BASE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_FIFO_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    op_t                op;
    logic [COUNT_W-1:0] mesh_count;
    logic [ID_W-1:0]    item_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic [CLASS_W-1:0] size_class;
    logic               reused;
    status_t            status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } dp_cmd_t;

  // Access request from the datapath to the free FIFO memories.
  typedef struct packed {
    logic               wr_en;
    logic [CLASS_W-1:0] wr_class;
    logic [PTR_W-1:0]   wr_addr;
    logic               rd_en;
    logic [CLASS_W-1:0] rd_class;
    logic [PTR_W-1:0]   rd_addr;
  } mem_req_t;

  // Number of IDs a class can mint.
  function automatic int class_cap(input int id_bits, input int sub_bits);
    return (sub_bits < id_bits - 2) ? (1 << (id_bits - 2 - sub_bits)) : 1;
  endfunction

  // Low bits that a base request clears.
  function automatic int clear_mask(input int id_bits, input int sub_bits);
    return (sub_bits < id_bits - 2) ? ((1 << sub_bits) - 1) : ((1 << (id_bits - 2)) - 1);
  endfunction

endpackage

FILE: rtl/scid_ctrl.sv
// ----------------------------------------------------------------------------
// scid_ctrl: request sequencer of the size-class ID allocator
// Takes a request, runs it in the datapath, then, once the response register
// is free, hands the result to it and takes the next request in that cycle.
// ----------------------------------------------------------------------------
module scid_ctrl
  import scid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        rsp_valid_next;

  // State and response valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_stall      = 1'b1;
    rsp_valid_next = rsp_valid && rsp_stall;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        // The response register is free once its transfer completes.
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          req_stall      = 1'b0;
          if (req_valid) begin
            cmd.load_in = 1'b1;
            state_next  = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/scid_fifo_mem.sv
// ----------------------------------------------------------------------------
// scid_fifo_mem: storage of the four free ID FIFOs
// One memory per class, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scid_fifo_mem
  import scid_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  mem_req_t           mem_req,
  input  logic [ID_BITS-1:0] wr_data,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem0 [FIFO_DEPTH[0]];
  logic [ID_BITS-1:0] mem1 [FIFO_DEPTH[1]];
  logic [ID_BITS-1:0] mem2 [FIFO_DEPTH[2]];
  logic [ID_BITS-1:0] mem3 [FIFO_DEPTH[3]];

  logic [ID_BITS-1:0] rd0;
  logic [ID_BITS-1:0] rd1;
  logic [ID_BITS-1:0] rd2;
  logic [ID_BITS-1:0] rd3;
  logic [CLASS_W-1:0] rd_class_q;

  // Write port: the class picks the memory.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      unique case (mem_req.wr_class)
        2'd0: mem0[mem_req.wr_addr[FIFO_AW[0]-1:0]] <= wr_data;
        2'd1: mem1[mem_req.wr_addr[FIFO_AW[1]-1:0]] <= wr_data;
        2'd2: mem2[mem_req.wr_addr[FIFO_AW[2]-1:0]] <= wr_data;
        default: mem3[mem_req.wr_addr[FIFO_AW[3]-1:0]] <= wr_data;
      endcase
    end
  end

  // Registered read of every memory; the class is kept for the output select.
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd0        <= mem0[mem_req.rd_addr[FIFO_AW[0]-1:0]];
      rd1        <= mem1[mem_req.rd_addr[FIFO_AW[1]-1:0]];
      rd2        <= mem2[mem_req.rd_addr[FIFO_AW[2]-1:0]];
      rd3        <= mem3[mem_req.rd_addr[FIFO_AW[3]-1:0]];
      rd_class_q <= mem_req.rd_class;
    end
  end

  always_comb begin
    unique case (rd_class_q)
      2'd0:    rd_data = rd0;
      2'd1:    rd_data = rd1;
      2'd2:    rd_data = rd2;
      default: rd_data = rd3;
    endcase
  end

endmodule

FILE: rtl/scid_datapath.sv
// ----------------------------------------------------------------------------
// scid_datapath: class selection, counters and FIFO pointers
// Holds the request, decides the outcome of allocate, free and base,
// keeps the class counters and FIFO pointers, and forms the response.
// ----------------------------------------------------------------------------
module scid_datapath
  import scid_pkg::*;
#(
  parameter int ID_BITS        = ID_BITS_DEF,
  parameter int MAX_MESH_COUNT = MAX_MESH_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  req_t               req,
  output rsp_t               rsp,
  output mem_req_t           mem_req,
  output logic [ID_BITS-1:0] mem_wr_data,
  input  logic [ID_BITS-1:0] mem_rd_data
);

  localparam int LOW_BITS = ID_BITS - 2;
  localparam int CNT_W    = ID_BITS - 3;

  req_t req_q;

  logic [CNT_W-1:0]  cnt_q     [NUM_CLASSES];
  logic [PTR_W-1:0]  rd_ptr_q  [NUM_CLASSES];
  logic [PTR_W-1:0]  wr_ptr_q  [NUM_CLASSES];
  logic [FILL_W-1:0] fill_q    [NUM_CLASSES];

  logic [NUM_CLASSES-1:0] at_cap;
  logic [NUM_CLASSES-1:0] fits;
  logic [NUM_CLASSES-1:0] fifo_full;
  logic [NUM_CLASSES-1:0] fifo_empty;
  logic [LOW_BITS-1:0]    mint_low  [NUM_CLASSES];
  logic [LOW_BITS-1:0]    clr_mask  [NUM_CLASSES];
  logic [PTR_W-1:0]       rd_inc    [NUM_CLASSES];
  logic [PTR_W-1:0]       wr_inc    [NUM_CLASSES];

  logic [ID_BITS-1:0]  id_m;
  logic [CLASS_W-1:0]  cls_id;
  logic [CLASS_W-1:0]  cls_alloc;
  logic                too_large;

  logic [ID_W-1:0]     ex_res;
  logic [CLASS_W-1:0]  ex_cls;
  logic                ex_reused;
  status_t             ex_status;
  logic                do_pop;
  logic                do_push;
  logic                do_mint;

  logic [ID_W-1:0]     res_q;
  logic [CLASS_W-1:0]  cls_q;
  logic                reused_q;
  status_t             status_q;

  // Per-class constants and status.
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    localparam int B   = SUB_BITS[c];
    localparam int CAP = class_cap(ID_BITS, B);
    logic [LOW_BITS+CNT_W-1:0] wide;

    assign wide          = {{LOW_BITS{1'b0}}, cnt_q[c]} << B;
    assign mint_low[c]   = wide[LOW_BITS-1:0];
    assign clr_mask[c]   = LOW_BITS'(clear_mask(ID_BITS, B));
    assign at_cap[c]     = cnt_q[c] >= CNT_W'(CAP);
    assign fits[c]       = {1'b0, req_q.mesh_count} <= (COUNT_W+1)'(1 << B);
    assign fifo_full[c]  = fill_q[c] >= FILL_W'(FIFO_DEPTH[c]);
    assign fifo_empty[c] = fill_q[c] == '0;
    assign rd_inc[c]     = PTR_W'(rd_ptr_q[c] + 1'b1) & PTR_W'(FIFO_DEPTH[c] - 1);
    assign wr_inc[c]     = PTR_W'(wr_ptr_q[c] + 1'b1) & PTR_W'(FIFO_DEPTH[c] - 1);
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q <= req;
    end
  end

  assign id_m   = req_q.item_id[ID_BITS-1:0];
  assign cls_id = id_m[ID_BITS-1 -: CLASS_W];

  // Smallest class whose sub-index bits can number the meshes.
  always_comb begin
    priority if (fits[0]) begin
      cls_alloc = 2'd0;
    end else if (fits[1]) begin
      cls_alloc = 2'd1;
    end else if (fits[2]) begin
      cls_alloc = 2'd2;
    end else begin
      cls_alloc = 2'd3;
    end
  end

  assign too_large = ({1'b0, req_q.mesh_count} >= (COUNT_W+1)'(MAX_MESH_COUNT)) || (fits == '0);

  // Outcome of the held request.
  always_comb begin
    ex_res    = '0;
    ex_cls    = '0;
    ex_reused = 1'b0;
    ex_status = ST_OK;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    do_mint   = 1'b0;
    unique case (req_q.op)
      OP_ALLOC: begin
        priority if (too_large) begin
          ex_status = ST_TOO_LARGE;
        end else if (!fifo_empty[cls_alloc]) begin
          ex_cls    = cls_alloc;
          ex_reused = 1'b1;
          do_pop    = 1'b1;
        end else if (at_cap[cls_alloc]) begin
          ex_cls    = cls_alloc;
          ex_status = ST_EXHAUSTED;
        end else begin
          ex_cls  = cls_alloc;
          ex_res  = ID_W'({cls_alloc, mint_low[cls_alloc]});
          do_mint = 1'b1;
        end
      end
      OP_FREE: begin
        ex_cls = cls_id;
        if (fifo_full[cls_id]) begin
          ex_status = ST_FIFO_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      OP_BASE: begin
        ex_cls = cls_id;
        ex_res = ID_W'({cls_id, id_m[LOW_BITS-1:0] & ~clr_mask[cls_id]});
      end
      default: begin
        ex_cls = '0;
      end
    endcase
  end

  // FIFO memory access for the executing request.
  always_comb begin
    mem_req          = '0;
    mem_req.wr_en    = cmd.exec && do_push;
    mem_req.wr_class = ex_cls;
    mem_req.wr_addr  = wr_ptr_q[ex_cls];
    mem_req.rd_en    = cmd.exec && do_pop;
    mem_req.rd_class = ex_cls;
    mem_req.rd_addr  = rd_ptr_q[ex_cls];
  end

  assign mem_wr_data = id_m;

  // Class counters, FIFO pointers and fill counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_q[c]    <= '0;
        rd_ptr_q[c] <= '0;
        wr_ptr_q[c] <= '0;
        fill_q[c]   <= '0;
      end
    end else if (cmd.exec) begin
      if (do_mint) begin
        cnt_q[ex_cls] <= cnt_q[ex_cls] + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q[ex_cls] <= rd_inc[ex_cls];
        fill_q[ex_cls]   <= fill_q[ex_cls] - 1'b1;
      end
      if (do_push) begin
        wr_ptr_q[ex_cls] <= wr_inc[ex_cls];
        fill_q[ex_cls]   <= fill_q[ex_cls] + 1'b1;
      end
    end
  end

  // Outcome registers, held until the response register takes them.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_q    <= ex_res;
      cls_q    <= ex_cls;
      reused_q <= ex_reused;
      status_q <= ex_status;
    end
  end

  // Response register; a reused ID comes from the FIFO read data.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.result_id  <= reused_q ? ID_W'(mem_rd_data) : res_q;
      rsp.size_class <= cls_q;
      rsp.reused     <= reused_q;
      rsp.status     <= status_q;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_q[0] <= FILL_W'(FIFO_DEPTH[0])) && (fill_q[1] <= FILL_W'(FIFO_DEPTH[1])) &&
    (fill_q[2] <= FILL_W'(FIFO_DEPTH[2])) && (fill_q[3] <= FILL_W'(FIFO_DEPTH[3])))
    else $error("free FIFO fill count beyond its depth");

  a_mint_below_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && do_mint |-> !at_cap[ex_cls])
    else $error("ID minted from a class at capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && do_pop |-> fill_q[ex_cls] != '0)
    else $error("pop from an empty free FIFO");

  a_reuse_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && reused_q |-> status_q == ST_OK && req_q.op == OP_ALLOC)
    else $error("reused ID with an error status");
`endif

endmodule

FILE: rtl/size_class_id_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_id_allocator_top: 16-bit ID allocator with four size classes
// Allocates IDs by mesh count, queues freed IDs per class for reuse, and
// reduces mesh IDs to their base ID.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (op, mesh_count, item_id) with req_valid/req_stall;
//   a transfer happens at a rising edge with valid high and stall low.
//   Every request yields exactly one response on rsp (result_id, size_class,
//   reused, status) with rsp_valid/rsp_stall.
//   The request is executed into the outcome registers, then loaded into the
//   response register; the free FIFO memories are read with a registered
//   port, so the sequencer executes the request in S_EXEC and forms the
//   response in S_RESULT, where it also takes the next request once the
//   response register is free.
//   When the receiver stalls, the response register holds its result and one
//   more request may be taken and executed; after that req_stall stays high
//   until the held response transfers.
//   Reset clears the class counters and empties every free FIFO at once; the
//   FIFO memories themselves are not cleared.
// ----------------------------------------------------------------------------
module size_class_id_allocator_top
  import scid_pkg::*;
#(
  parameter int ID_BITS        = ID_BITS_DEF,
  parameter int MAX_MESH_COUNT = MAX_MESH_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  dp_cmd_t            cmd;
  mem_req_t           mem_req;
  logic [ID_BITS-1:0] mem_wr_data;
  logic [ID_BITS-1:0] mem_rd_data;

  scid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  scid_datapath #(
    .ID_BITS        (ID_BITS),
    .MAX_MESH_COUNT (MAX_MESH_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (req),
    .rsp         (rsp),
    .mem_req     (mem_req),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  scid_fifo_mem #(
    .ID_BITS (ID_BITS)
  ) u_fifo_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

endmodule

FILE: tb/sv/scid_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scid_checker: response predictor and scoreboard for the ID allocator
// Watches both channels of the allocator. Every request transfer updates a
// private copy of the class counters and free FIFOs and queues the response
// it owes. Every response transfer is compared field by field with the
// oldest owed response.
// ----------------------------------------------------------------------------
module scid_checker
  import scid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   err_count,
  output int   pending_count
);

  // Width of the sub-index field below the class bits.
  localparam int LOW_W = ID_BITS_DEF - 2;

  // Predicted allocator state.
  int unsigned     minted [NUM_CLASSES];
  int unsigned     rd_ptr [NUM_CLASSES];
  int unsigned     wr_ptr [NUM_CLASSES];
  int unsigned     fill   [NUM_CLASSES];
  logic [ID_W-1:0] free_ids [NUM_CLASSES][4096];

  // Responses owed by the allocator, oldest first.
  rsp_t owed_rsp [$];

  initial begin
    err_count     = 0;
    pending_count = 0;
  end

  // Work out the response to one request and advance the predicted state.
  function automatic rsp_t allocator_outcome(input req_t r);
    rsp_t        o;
    int unsigned need;
    int unsigned span;
    int unsigned limit;
    int          c;
    o = '0;
    case (r.op)
      OP_ALLOC: begin
        // Needed bits are the bit length of count-1; smallest class that fits.
        need = 0;
        span = (r.mesh_count == '0) ? 0 : r.mesh_count - 1;
        while (span != 0) begin
          need++;
          span >>= 1;
        end
        c = -1;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
          if (need <= SUB_BITS[i]) c = i;
        end
        if (r.mesh_count >= MAX_MESH_COUNT_DEF || c < 0) begin
          o.status = ST_TOO_LARGE;
        end else begin
          o.size_class = CLASS_W'(c);
          limit = (SUB_BITS[c] < LOW_W) ? (1 << (LOW_W - SUB_BITS[c])) : 1;
          if (fill[c] != 0) begin
            // A freed ID of this class is handed out first.
            o.result_id = free_ids[c][rd_ptr[c]];
            o.reused    = 1'b1;
            rd_ptr[c]   = (rd_ptr[c] + 1) % FIFO_DEPTH[c];
            fill[c]--;
          end else if (minted[c] >= limit) begin
            o.status = ST_EXHAUSTED;
          end else begin
            o.result_id = ID_W'(c << LOW_W) |
                          ID_W'((minted[c] << SUB_BITS[c]) & ((1 << LOW_W) - 1));
            minted[c]++;
          end
        end
      end
      OP_FREE: begin
        // The top bits name the class; a full FIFO drops the ID.
        c = int'(r.item_id[ID_W-1 -: CLASS_W]);
        o.size_class = r.item_id[ID_W-1 -: CLASS_W];
        if (fill[c] >= FIFO_DEPTH[c]) begin
          o.status = ST_FIFO_FULL;
        end else begin
          free_ids[c][wr_ptr[c]] = r.item_id;
          wr_ptr[c] = (wr_ptr[c] + 1) % FIFO_DEPTH[c];
          fill[c]++;
        end
      end
      OP_BASE: begin
        c = int'(r.item_id[ID_W-1 -: CLASS_W]);
        o.size_class = r.item_id[ID_W-1 -: CLASS_W];
        limit = (SUB_BITS[c] < LOW_W) ? ((1 << SUB_BITS[c]) - 1) : ((1 << LOW_W) - 1);
        o.result_id = r.item_id & ~ID_W'(limit);
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Compare response transfers, then record what each request transfer owes.
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        minted[i] = 0;
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
        fill[i]   = 0;
      end
      owed_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("[%0t] unexpected response: id=%h class=%0d reused=%0b status=%0d",
                     $realtime, rsp.result_id, rsp.size_class, rsp.reused, rsp.status);
          end
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.result_id !== want.result_id || rsp.size_class !== want.size_class ||
              rsp.reused !== want.reused || rsp.status !== want.status) begin
            err_count++;
            if (err_count <= 10) begin
              $display("[%0t] response mismatch: want id=%h class=%0d reused=%0b status=%0d",
                       $realtime, want.result_id, want.size_class, want.reused, want.status);
              $display("            got  id=%h class=%0d reused=%0b status=%0d",
                       rsp.result_id, rsp.size_class, rsp.reused, rsp.status);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        owed_rsp.push_back(allocator_outcome(req));
      end
    end
    pending_count = owed_rsp.size();
  end

endmodule

FILE: tb/sv/tb_size_class_id_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_id_allocator_top: stimulus and verdict for the ID allocator
// Drives directed corner requests, a bulk phase that exhausts and overfills
// the two largest classes, and a long random mix with gaps and stalls on both
// channels. The checker beside the allocator predicts and compares.
// ----------------------------------------------------------------------------
module tb_size_class_id_allocator_top;
  import scid_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1060;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int err_count;
  int pending_count;
  int idle_cycles = 0;

  // Shared between the sender and the receiver: no idling, and long holds.
  bit calm        = 1'b0;
  int hold_asks   = 0;
  int hold_served = 0;

  always #6 clk = ~clk;

  size_class_id_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  scid_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  function automatic req_t make_req(input op_t op, input int cnt, input int id);
    req_t r;
    r.op         = op;
    r.mesh_count = COUNT_W'(cnt);
    r.item_id    = ID_W'(id);
    return r;
  endfunction

  // Mesh count that lands in class c; anything past the last class is too large.
  function automatic int class_count(input int c);
    case (c)
      0:       return $urandom_range(0, 4);
      1:       return $urandom_range(5, 32);
      2:       return $urandom_range(33, 256);
      3:       return $urandom_range(257, 2047);
      default: return $urandom_range(2048, 4095);
    endcase
  endfunction

  // Well-formed base ID of class c with a random slot.
  function automatic int class_id(input int c);
    int slots;
    slots = 1 << (ID_BITS_DEF - 2 - SUB_BITS[c]);
    return (c << (ID_BITS_DEF - 2)) | ($urandom_range(0, slots - 1) << SUB_BITS[c]);
  endfunction

  // Offer one request after a random gap and wait for its transfer.
  task automatic send_req(input req_t r);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap  = (calm || roll < 55) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Response side: random stalls, a few long ones, and a long hold on request.
  initial begin
    int roll;
    forever begin
      @(negedge clk);
      roll = $urandom_range(0, 99);
      if (hold_served < hold_asks) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_served++;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else if (roll < 3) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(negedge clk);
      end else begin
        rsp_stall <= (roll < 28);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_size_class_id_allocator_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Request stream and verdict.
  initial begin
    req_t opening [$];
    int   roll;
    int   pick;
    int   c;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corner requests: class boundaries, oversized counts, reuse, double
    // free, never-issued IDs, base of every class, and the unused op.
    opening.push_back(make_req(OP_ALLOC, 0, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 1, 'hFFFF));
    opening.push_back(make_req(OP_ALLOC, 4, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 5, 'h1234));
    opening.push_back(make_req(OP_ALLOC, 32, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 33, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 256, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 257, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 2047, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 2048, 'h0000));
    opening.push_back(make_req(OP_ALLOC, 4095, 'hFFFF));
    opening.push_back(make_req(OP_FREE, 0, 'h0004));
    opening.push_back(make_req(OP_FREE, 4095, 'h0004));
    opening.push_back(make_req(OP_ALLOC, 2, 'h0000));
    opening.push_back(make_req(OP_FREE, 0, 'hFFFF));
    opening.push_back(make_req(OP_FREE, 0, 'h0000));
    opening.push_back(make_req(OP_FREE, 0, 'h8000));
    opening.push_back(make_req(OP_BASE, 0, 'hFFFF));
    opening.push_back(make_req(OP_BASE, 4095, 'h0000));
    opening.push_back(make_req(OP_BASE, 0, 'h7ABC));
    opening.push_back(make_req(OP_BASE, 0, 'hBFFF));
    opening.push_back(make_req(OP_BASE, 0, 'h5555));
    opening.push_back(make_req(OP_NONE, 4095, 'hFFFF));
    opening.push_back(make_req(OP_NONE, 0, 'h0000));
    foreach (opening[i]) send_req(opening[i]);

    // Mint class 3 and class 2 dry, then overfill their free FIFOs.
    repeat (12) send_req(make_req(OP_ALLOC, class_count(3), $urandom));
    repeat (12) send_req(make_req(OP_FREE, $urandom, class_id(3)));
    repeat (70) send_req(make_req(OP_ALLOC, class_count(2), $urandom));
    repeat (70) send_req(make_req(OP_FREE, $urandom, class_id(2)));

    // Random mix; a long response hold and two stretches without idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_asks++;
      calm = (n >= 300 && n < 330) || (n >= 700 && n < 800);
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      c    = (pick < 25) ? 0 : (pick < 50) ? 1 : (pick < 75) ? 2 : (pick < 90) ? 3 : 4;
      if (roll < 45) begin
        send_req(make_req(OP_ALLOC, class_count(c), $urandom));
      end else if (roll < 80) begin
        send_req(make_req(OP_FREE, $urandom, (c < 4) ? class_id(c) : $urandom));
      end else if (roll < 95) begin
        send_req(make_req(OP_BASE, $urandom, (c < 2) ? class_id(c + 2) : $urandom));
      end else begin
        send_req(make_req(OP_NONE, $urandom, $urandom));
      end
    end
    calm = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (err_count == 0 && pending_count == 0) begin
      $display("tb_size_class_id_allocator_top: clean");
    end else begin
      $display("tb_size_class_id_allocator_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/scid_pkg.sv
rtl/scid_ctrl.sv
rtl/scid_fifo_mem.sv
rtl/scid_datapath.sv
rtl/size_class_id_allocator_top.sv
tb/sv/scid_checker.sv
tb/sv/tb_size_class_id_allocator_top.sv
